@@ sv/sdspi_pkg.sv @@
package sdspi_pkg;

   // Field widths.
   localparam int ByteW       = 8;
   localparam int ArgW        = 32;
   localparam int ReadyCountW = 20;
   localparam int PollCountW  = 8;
   localparam int FrameIdxW   = 3;
   localparam int CmdIdxW     = 6;
   localparam int CsrDataW    = 20;
   localparam int CsrIndexW   = 1;

   // Configuration register indexes.
   localparam logic [CsrIndexW-1:0] CSR_READY_LIMIT = 1'd0;
   localparam logic [CsrIndexW-1:0] CSR_POLL_LIMIT  = 1'd1;

   // Reset values of the configuration registers.
   localparam logic [ReadyCountW-1:0] READY_LIMIT_RST = 20'd500000;
   localparam logic [PollCountW-1:0]  POLL_LIMIT_RST  = 8'd10;

   // Request modes.
   localparam logic MODE_COMMAND = 1'b0;
   localparam logic MODE_RX_BYTE = 1'b1;

   // Command indexes with special handling.
   localparam logic [CmdIdxW-1:0] CMD_GO_IDLE   = 6'd0;
   localparam logic [CmdIdxW-1:0] CMD_SEND_IF   = 6'd8;
   localparam logic [CmdIdxW-1:0] CMD_STOP      = 6'd12;
   localparam logic [CmdIdxW-1:0] CMD_APP_CMD   = 6'd55;

   // Byte constants.
   localparam logic [ByteW-1:0] BYTE_IDLE     = 8'hFF;
   localparam logic [ByteW-1:0] BYTE_START    = 8'h40;
   localparam logic [ByteW-1:0] CRC_GO_IDLE   = 8'h95;
   localparam logic [ByteW-1:0] CRC_SEND_IF   = 8'h87;
   localparam logic [ByteW-1:0] CRC_DEFAULT   = 8'h01;
   localparam logic [ByteW-1:0] R1_MAX_OK     = 8'h01;
   localparam logic [FrameIdxW-1:0] FRAME_LEN = 3'd6;

   // Command phase, one-hot.
   typedef enum logic [7:0] {
      PH_IDLE     = 8'b0000_0001,
      PH_DESEL    = 8'b0000_0010,
      PH_SELDUMMY = 8'b0000_0100,
      PH_WAITRDY  = 8'b0000_1000,
      PH_TIMEOUT  = 8'b0001_0000,
      PH_FRAME    = 8'b0010_0000,
      PH_DISCARD  = 8'b0100_0000,
      PH_POLL     = 8'b1000_0000
   } phase_type;

   // Configuration seen by the sequencer.
   typedef struct packed {
      logic [ReadyCountW-1:0] ready_limit;
      logic [PollCountW-1:0]  poll_limit;
   } cfg_type;

   // One result item.
   typedef struct packed {
      logic             tx_valid;
      logic [ByteW-1:0] tx_byte;
      logic             chip_select;
      logic             done_res;
      logic [ByteW-1:0] response;
      logic             ready_timeout;
   } rsp_type;

   // Index of the command being issued; the prefix is always CMD55.
   function automatic logic [CmdIdxW-1:0] cur_index(input logic prefix,
                                                    input logic [ByteW-1:0] command);
      cur_index = prefix ? CMD_APP_CMD : command[CmdIdxW-1:0];
   endfunction

   // Byte i of the six-byte command frame.
   function automatic logic [ByteW-1:0] frame_byte(input logic [CmdIdxW-1:0] idx,
                                                   input logic [ArgW-1:0] arg,
                                                   input logic [FrameIdxW-1:0] i);
      logic [ByteW-1:0] b;
      case (i)
         3'd0:    b = BYTE_START | {2'b00, idx};
         3'd1:    b = arg[31:24];
         3'd2:    b = arg[23:16];
         3'd3:    b = arg[15:8];
         3'd4:    b = arg[7:0];
         default: begin
            if (idx == CMD_GO_IDLE) begin
               b = CRC_GO_IDLE;
            end else if (idx == CMD_SEND_IF) begin
               b = CRC_SEND_IF;
            end else begin
               b = CRC_DEFAULT;
            end
         end
      endcase
      frame_byte = b;
   endfunction

endpackage

@@ sv/sdspi_seq.sv @@
module sdspi_seq
   import sdspi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  mode,
   input  logic [ByteW-1:0]      command,
   input  logic [ArgW-1:0]       argument,
   input  logic [ByteW-1:0]      rx_byte,
   input  cfg_type               cfg,
   output logic                  res_load,
   output rsp_type               res
);

   phase_type               phase_ff, phase_in;
   logic [ByteW-1:0]        cmd_ff, cmd_in;
   logic [ArgW-1:0]         arg_ff, arg_in;
   logic                    pfx_ff, pfx_in;
   logic [FrameIdxW-1:0]    fbi_ff, fbi_in;
   logic [ReadyCountW-1:0]  rc_ff, rc_in;
   logic [PollCountW-1:0]   pc_ff, pc_in;
   logic                    sel_ff, sel_in;

   logic                    start_cmd;
   logic [CmdIdxW-1:0]      idx_cur;
   logic [CmdIdxW-1:0]      idx_new;
   logic [ArgW-1:0]         arg_cur;
   logic [ArgW-1:0]         arg_new;
   logic [FrameIdxW-1:0]    fbi_next;
   logic [PollCountW-1:0]   pc_next;

   assign idx_cur  = cur_index(pfx_ff, cmd_ff);
   assign arg_cur  = pfx_ff ? '0 : arg_ff;
   assign fbi_next = fbi_ff + 3'd1;
   assign pc_next  = pc_ff + 8'd1;

   // Next state and result for one accepted request.
   always_comb begin
      phase_in  = phase_ff;
      cmd_in    = cmd_ff;
      arg_in    = arg_ff;
      pfx_in    = pfx_ff;
      fbi_in    = fbi_ff;
      rc_in     = rc_ff;
      pc_in     = pc_ff;
      sel_in    = sel_ff;
      start_cmd = 1'b0;
      res_load  = 1'b0;
      res       = '0;
      idx_new   = '0;
      arg_new   = '0;

      if (step) begin
         if (mode == MODE_COMMAND) begin
            if (phase_ff == PH_IDLE) begin
               cmd_in    = command;
               arg_in    = argument;
               pfx_in    = command[7];
               start_cmd = 1'b1;
            end
         end else begin
            unique case (phase_ff)
               PH_DESEL: begin
                  sel_in       = 1'b0;
                  phase_in     = PH_SELDUMMY;
                  res_load     = 1'b1;
                  res.tx_valid = 1'b1;
                  res.tx_byte  = BYTE_IDLE;
               end
               PH_SELDUMMY: begin
                  rc_in        = '0;
                  phase_in     = PH_WAITRDY;
                  res_load     = 1'b1;
                  res.tx_valid = 1'b1;
                  res.tx_byte  = BYTE_IDLE;
               end
               PH_WAITRDY: begin
                  res_load     = 1'b1;
                  res.tx_valid = 1'b1;
                  if (rx_byte == BYTE_IDLE) begin
                     fbi_in      = '0;
                     phase_in    = PH_FRAME;
                     res.tx_byte = frame_byte(idx_cur, arg_cur, 3'd0);
                  end else if (rc_ff == cfg.ready_limit) begin
                     sel_in      = 1'b1;
                     phase_in    = PH_TIMEOUT;
                     res.tx_byte = BYTE_IDLE;
                  end else begin
                     rc_in       = rc_ff + 20'd1;
                     res.tx_byte = BYTE_IDLE;
                  end
               end
               PH_TIMEOUT: begin
                  res_load          = 1'b1;
                  res.done_res      = 1'b1;
                  res.response      = BYTE_IDLE;
                  res.ready_timeout = 1'b1;
                  phase_in          = PH_IDLE;
                  pfx_in            = 1'b0;
               end
               PH_FRAME: begin
                  fbi_in       = fbi_next;
                  res_load     = 1'b1;
                  res.tx_valid = 1'b1;
                  res.tx_byte  = BYTE_IDLE;
                  if (fbi_next < FRAME_LEN) begin
                     res.tx_byte = frame_byte(idx_cur, arg_cur, fbi_next);
                  end else if (idx_cur == CMD_STOP) begin
                     phase_in = PH_DISCARD;
                  end else begin
                     pc_in    = '0;
                     phase_in = PH_POLL;
                  end
               end
               PH_DISCARD: begin
                  pc_in        = '0;
                  phase_in     = PH_POLL;
                  res_load     = 1'b1;
                  res.tx_valid = 1'b1;
                  res.tx_byte  = BYTE_IDLE;
               end
               PH_POLL: begin
                  if (rx_byte[7] && (pc_next != cfg.poll_limit)) begin
                     pc_in        = pc_next;
                     res_load     = 1'b1;
                     res.tx_valid = 1'b1;
                     res.tx_byte  = BYTE_IDLE;
                  end else if (pfx_ff && (rx_byte <= R1_MAX_OK)) begin
                     // Prefix accepted: go on with the real command.
                     pfx_in    = 1'b0;
                     start_cmd = 1'b1;
                  end else begin
                     res_load     = 1'b1;
                     res.done_res = 1'b1;
                     res.response = rx_byte;
                     phase_in     = PH_IDLE;
                     pfx_in       = 1'b0;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end

         // Start of a command: select step, or straight to the frame for CMD12.
         if (start_cmd) begin
            idx_new      = cur_index(pfx_in, cmd_in);
            arg_new      = pfx_in ? '0 : arg_in;
            res_load     = 1'b1;
            res.tx_valid = 1'b1;
            if (idx_new != CMD_STOP) begin
               sel_in      = 1'b1;
               phase_in    = PH_DESEL;
               res.tx_byte = BYTE_IDLE;
            end else begin
               fbi_in      = '0;
               phase_in    = PH_FRAME;
               res.tx_byte = frame_byte(idx_new, arg_new, 3'd0);
            end
         end
      end

      res.chip_select = sel_in;
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cmd_ff   <= '0;
         arg_ff   <= '0;
         pfx_ff   <= 1'b0;
         fbi_ff   <= '0;
         rc_ff    <= '0;
         pc_ff    <= '0;
         sel_ff   <= 1'b1;
      end else begin
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         arg_ff   <= arg_in;
         pfx_ff   <= pfx_in;
         fbi_ff   <= fbi_in;
         rc_ff    <= rc_in;
         pc_ff    <= pc_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

@@ sv/sdspi_rsp_reg.sv @@
module sdspi_rsp_reg
   import sdspi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    can_load,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   // The register takes a new result when empty or when its result leaves now.
   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

@@ sv/sd_spi_command_engine.sv @@
// Channel  Handshake            Payload ports, after the channel prefix
// req      req_valid/req_ready  mode, command, argument, rx_byte
// rsp      rsp_valid/rsp_ready  tx_valid, tx_byte, chip_select, done_res, response, ready_timeout
// csr      csr_valid/csr_ready  index, data
//
// Each request is decided by the phase sequencer and its result, if any, lands
// in the output register on the next edge; one request per cycle unless the register is held full.
// A request is taken whenever the output register is empty or being read.
// Reset is synchronous and active high; it returns the sequencer to idle with
// chip select high and restores the default limits. Configuration writes are
// always taken.
module sd_spi_command_engine
   import sdspi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_mode,
   input  logic [ByteW-1:0]      req_command,
   input  logic [ArgW-1:0]       req_argument,
   input  logic [ByteW-1:0]      req_rx_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_tx_valid,
   output logic [ByteW-1:0]      rsp_tx_byte,
   output logic                  rsp_chip_select,
   output logic                  rsp_done_res,
   output logic [ByteW-1:0]      rsp_response,
   output logic                  rsp_ready_timeout,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CsrIndexW-1:0]  csr_index,
   input  logic [CsrDataW-1:0]   csr_data
);

   logic [ReadyCountW-1:0] ready_limit_ff, ready_limit_in;
   logic [PollCountW-1:0]  poll_limit_ff, poll_limit_in;
   cfg_type                cfg;
   logic                   step;
   logic                   res_load;
   rsp_type                res;
   rsp_type                rsp_data;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      ready_limit_in = ready_limit_ff;
      poll_limit_in  = poll_limit_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_READY_LIMIT: ready_limit_in = csr_data[ReadyCountW-1:0];
            CSR_POLL_LIMIT:  poll_limit_in  = csr_data[PollCountW-1:0];
            default:         ready_limit_in = ready_limit_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_limit_ff <= READY_LIMIT_RST;
         poll_limit_ff  <= POLL_LIMIT_RST;
      end else begin
         ready_limit_ff <= ready_limit_in;
         poll_limit_ff  <= poll_limit_in;
      end
   end

   assign cfg.ready_limit = ready_limit_ff;
   assign cfg.poll_limit  = poll_limit_ff;

   // Request accepted this cycle.
   assign step = req_valid && req_ready;

   sdspi_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .mode     (req_mode),
      .command  (req_command),
      .argument (req_argument),
      .rx_byte  (req_rx_byte),
      .cfg      (cfg),
      .res_load (res_load),
      .res      (res)
   );

   sdspi_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (res_load),
      .load_data (res),
      .can_load  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_tx_valid      = rsp_data.tx_valid;
   assign rsp_tx_byte       = rsp_data.tx_byte;
   assign rsp_chip_select   = rsp_data.chip_select;
   assign rsp_done_res      = rsp_data.done_res;
   assign rsp_response      = rsp_data.response;
   assign rsp_ready_timeout = rsp_data.ready_timeout;

endmodule
